[rtl/htb_pkg.sv]
// htb_pkg: opcodes, status codes and shared constants of the Huffman tree builder.
// No dependencies.
`timescale 1ns / 1ps
package htb_pkg;
    localparam int ID_BITS    = 9;
    localparam int OUT_FREQ_W = 48;
    localparam int HEAP_DEPTH = 512;
    localparam int HADDR_W    = 9;
    localparam int HCNT_W     = 10;

    typedef enum logic [1:0] {
        t_OP_LOAD  = 2'd0,
        t_OP_MERGE = 2'd1,
        t_OP_CLEAR = 2'd2,
        t_OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        t_ST_LOADED  = 3'd0,
        t_ST_SKIPPED = 3'd1,
        t_ST_MERGED  = 3'd2,
        t_ST_ROOT    = 3'd3,
        t_ST_EMPTY   = 3'd4,
        t_ST_CLEARED = 3'd5,
        t_ST_FULL    = 3'd6
    } t_status;

    localparam logic [ID_BITS-1:0] NO_CHILD = '1;
endpackage

[rtl/huffman_tree_builder.sv]
// huffman_tree_builder: heap-based Huffman tree construction, single module.
// Depends on htb_pkg.
`timescale 1ns / 1ps
// Usage:
//  Input stream s_axis: tdata = {frequency[47:0], symbol[7:0], opcode[1:0]}
//  packed from bit 0, padded to 64 bits. Output stream m_axis: tdata =
//  {tree_done, parent_freq[47:0], parent_node, right_node, left_node, status}
//  from bit 0, padded to 80 bits. Each item except opcode 3 gives one result.
//  One item is worked at a time by a sequencer around one heap memory with
//  a single registered read port and one compare unit. An extraction reads
//  the root and the last entry, then walks down the heap level by level
//  (left read, right read, compare and write); an insertion walks up level
//  by level (read parent, then compare and write). Load: one insertion.
//  Merge: two extractions and one insertion, or with a lone entry one
//  extraction that gives a root. Clear, skip and status-only items go
//  straight to the output register.
//  Reset (synchronous, active low) empties the heap and node counter; no
//  clearing pass is needed since only entries below the count are read.
//  When the receiver stalls, the result holds in the output register and the
//  block takes no new item until that transfer completes.
module huffman_tree_builder #(
    parameter int SYMBOLS   = 256,
    parameter int FREQ_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], symbol[9:2], frequency[57:10], zero pad
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], left_node[11:3], right_node[20:12], parent_node[29:21],
    // parent_freq[77:30], tree_done[78], zero pad
    output logic [79:0] m_axis_tdata
);
    localparam int IW = htb_pkg::ID_BITS;
    localparam int AW = htb_pkg::HADDR_W;
    localparam int CW = htb_pkg::HCNT_W;
    localparam int FW = FREQ_BITS;
    localparam int EW = FW + IW;
    localparam logic [63:0] FMAX64 = (64'd1 << FW) - 64'd1;
    localparam logic [63:0] OUT_MAX64 = 64'h0000_FFFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH_RD, S_PUSH_CMP, S_POP_TOP, S_POP_LAST, S_POP_CUR,
        S_POP_LRD, S_POP_RRD, S_POP_CMP, S_POP_DONE, S_OUT
    } t_state;

    // Report saturation to the 48-bit output field
    function automatic logic [47:0] sat48(input logic [FW-1:0] f);
        logic [63:0] w;
        w = 64'(f);
        if (w > OUT_MAX64) return '1;
        return w[47:0];
    endfunction

    // Heap memory: one write port, one registered read port
    logic [EW-1:0] r_mem [htb_pkg::HEAP_DEPTH];
    logic [EW-1:0] r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_icnt;
    logic [CW-1:0] r_k;          // current heap position
    logic [EW-1:0] r_cur;        // entry being sifted
    logic [EW-1:0] r_best;       // smaller of current and left child
    logic [CW-1:0] r_bidx;
    logic          r_second;     // second extraction of a merge
    logic          r_merge;      // merge with two extractions
    logic [EW-1:0] r_first;      // first extracted
    logic [EW-1:0] r_sec;        // second extracted
    logic [2:0]    r_st;
    logic [IW-1:0] r_ln, r_rn, r_pn;
    logic [47:0]   r_pf;
    logic          r_done;

    logic [1:0]  in_op;
    logic [7:0]  in_sym;
    logic [47:0] in_freq;
    assign in_op   = s_axis_tdata[1:0];
    assign in_sym  = s_axis_tdata[9:2];
    assign in_freq = s_axis_tdata[57:10];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {1'b0, r_done, r_pf, r_pn, r_rn, r_ln, r_st};

    // Parent and child addresses
    logic [CW-1:0] par_k, lch, rch;
    assign par_k = (r_k - CW'(1)) >> 1;
    assign lch   = {r_k[CW-2:0], 1'b0} + CW'(1);
    assign rch   = {r_k[CW-2:0], 1'b0} + CW'(2);

    logic [FW-1:0] cur_f, rd_f, best_f, first_f, sec_f;
    assign cur_f   = r_cur[EW-1:IW];
    assign rd_f    = r_rd[EW-1:IW];
    assign best_f  = r_best[EW-1:IW];
    assign first_f = r_first[EW-1:IW];
    assign sec_f   = r_sec[EW-1:IW];

    // Saturated sum of the two extracted frequencies
    logic [FW:0]   sum_w;
    logic [FW-1:0] sum_s;
    assign sum_w = {1'b0, first_f} + {1'b0, sec_f};
    assign sum_s = sum_w[FW] ? '1 : sum_w[FW-1:0];

    logic [IW-1:0] new_id;
    assign new_id = IW'(SYMBOLS) + r_icnt;

    // Clamp of loaded frequency
    logic [63:0]   in_freq_w;
    logic [FW-1:0] ld_f;
    assign in_freq_w = 64'(in_freq);
    assign ld_f      = (in_freq_w > FMAX64) ? '1 : in_freq_w[FW-1:0];

    // Sift decisions
    logic          push_up, l_in, r_take;
    logic [CW-1:0] pick_idx;
    logic [EW-1:0] pick_ent;
    assign push_up  = (r_k != '0) && (rd_f > cur_f);
    assign l_in     = (lch < r_cnt);
    assign r_take   = (rch < r_cnt) && (rd_f < best_f);
    assign pick_idx = r_take ? rch : r_bidx;
    assign pick_ent = r_take ? r_rd : r_best;

    // Memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_k[AW-1:0];
        mem_wd = r_cur;
        mem_ra = '0;
        unique case (r_state)
            S_PUSH_RD:  mem_ra = par_k[AW-1:0];
            S_PUSH_CMP: begin
                mem_we = 1'b1;
                if (push_up) begin
                    mem_wd = r_rd;
                end
            end
            S_POP_LAST: mem_ra = r_cnt[AW-1:0];
            S_POP_LRD: begin
                mem_ra = lch[AW-1:0];
                mem_we = !l_in;
            end
            S_POP_RRD:  mem_ra = rch[AW-1:0];
            S_POP_CMP: begin
                mem_we = 1'b1;
                if (pick_idx != r_k) begin
                    mem_wd = pick_ent;
                end
            end
            default:    mem_ra = '0;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_icnt   <= '0;
            r_second <= 1'b0;
            r_merge  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ln <= '0; r_rn <= '0; r_pn <= '0; r_pf <= '0; r_done <= 1'b0;
                        unique case (in_op)
                            htb_pkg::t_OP_LOAD: begin
                                if (in_freq == 48'd0 || {24'd0, in_sym} >= 32'(SYMBOLS)) begin
                                    r_st <= htb_pkg::t_ST_SKIPPED; r_state <= S_OUT;
                                end else if (r_cnt == CW'(htb_pkg::HEAP_DEPTH)) begin
                                    r_st <= htb_pkg::t_ST_FULL; r_state <= S_OUT;
                                end else begin
                                    r_st  <= htb_pkg::t_ST_LOADED;
                                    r_k   <= r_cnt;
                                    r_cur <= {ld_f, IW'(in_sym)};
                                    r_cnt <= r_cnt + CW'(1);
                                    r_state <= S_PUSH_RD;
                                end
                            end
                            htb_pkg::t_OP_MERGE: begin
                                if (r_cnt == '0) begin
                                    r_st <= htb_pkg::t_ST_EMPTY; r_state <= S_OUT;
                                end else begin
                                    r_cnt    <= r_cnt - CW'(1);
                                    r_merge  <= (r_cnt != CW'(1));
                                    r_second <= 1'b0;
                                    r_state  <= S_POP_TOP;
                                end
                            end
                            htb_pkg::t_OP_CLEAR: begin
                                r_cnt <= '0; r_icnt <= '0;
                                r_st <= htb_pkg::t_ST_CLEARED; r_state <= S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_PUSH_RD: r_state <= S_PUSH_CMP;
                S_PUSH_CMP: begin
                    // parent data in r_rd; write done by port logic
                    if (push_up) begin
                        r_k <= par_k;
                        r_state <= S_PUSH_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_POP_TOP: r_state <= S_POP_LAST;
                S_POP_LAST: begin
                    // r_rd holds the root
                    if (r_second) begin
                        r_sec <= r_rd;
                    end else begin
                        r_first <= r_rd;
                    end
                    r_state <= S_POP_CUR;
                end
                S_POP_CUR: begin
                    // r_rd holds the last entry, now moving to the top
                    r_cur <= r_rd;
                    r_k   <= '0;
                    r_state <= S_POP_LRD;
                end
                S_POP_LRD: begin
                    // no child left: entry written back by port logic
                    if (l_in) begin
                        r_state <= S_POP_RRD;
                    end else begin
                        r_state <= S_POP_DONE;
                    end
                end
                S_POP_RRD: begin
                    // left child in r_rd; ties stay with the current entry
                    if (rd_f < cur_f) begin
                        r_best <= r_rd;
                        r_bidx <= lch;
                    end else begin
                        r_best <= r_cur;
                        r_bidx <= r_k;
                    end
                    r_state <= S_POP_CMP;
                end
                S_POP_CMP: begin
                    if (pick_idx != r_k) begin
                        r_k <= pick_idx;
                        r_state <= S_POP_LRD;
                    end else begin
                        r_state <= S_POP_DONE;
                    end
                end
                S_POP_DONE: begin
                    if (r_merge && !r_second) begin
                        r_second <= 1'b1;
                        r_cnt    <= r_cnt - CW'(1);
                        r_state  <= S_POP_TOP;
                    end else if (!r_merge) begin
                        // lone entry becomes a root with only a left child
                        r_st   <= htb_pkg::t_ST_ROOT;
                        r_ln   <= r_first[IW-1:0];
                        r_rn   <= htb_pkg::NO_CHILD;
                        r_pn   <= new_id;
                        r_pf   <= sat48(first_f);
                        r_done <= 1'b1;
                        r_icnt <= r_icnt + IW'(1);
                        r_state <= S_OUT;
                    end else begin
                        // insert the new internal node
                        r_st   <= htb_pkg::t_ST_MERGED;
                        r_ln   <= r_first[IW-1:0];
                        r_rn   <= r_sec[IW-1:0];
                        r_pn   <= new_id;
                        r_pf   <= sat48(sum_s);
                        r_done <= (r_cnt == '0);
                        r_icnt <= r_icnt + IW'(1);
                        r_k    <= r_cnt;
                        r_cur  <= {sum_s, new_id};
                        r_cnt  <= r_cnt + CW'(1);
                        r_state <= S_PUSH_RD;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(htb_pkg::HEAP_DEPTH));
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid));
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= htb_pkg::t_ST_FULL);
endmodule
